// File: rtl/prsd_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and helpers of the palette RLE sprite line decoder.
package prsd_pkg;

	localparam int unsigned MAX_LINE_WIDTH_DEF = 4095;
	localparam int unsigned QUEUE_DEPTH        = 4;
	localparam int unsigned PAL_DEPTH          = 256;
	localparam int unsigned PAL_WIDTH          = 16;

	localparam logic [11:0] LINE_WIDTH_RST   = 12'd320;
	localparam logic [11:0] START_OFFSET_RST = 12'd0;

	// configuration register indexes
	localparam logic CFG_LINE_WIDTH   = 1'b0;
	localparam logic CFG_START_OFFSET = 1'b1;

	// input opcodes
	localparam logic OP_STREAM    = 1'b0;
	localparam logic OP_PAL_WRITE = 1'b1;

	// header classes, top two bits of a header byte
	localparam logic [1:0] HDR_ALPHA   = 2'b00;
	localparam logic [1:0] HDR_LITERAL = 2'b01;
	localparam logic [1:0] HDR_REPEAT  = 2'b10;
	localparam logic [1:0] HDR_SKIP    = 2'b11;

	localparam logic [7:0] ALPHA_MAX = 8'd31;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_A1_INDEX,
		PH_RA_LEVEL,
		PH_RA_INDEX,
		PH_LITERAL,
		PH_REP_INDEX
	} phase_t;

	typedef enum logic [2:0] {
		CMD_WRITE,
		CMD_ALPHA,
		CMD_OPAQUE,
		CMD_CLEAR,
		CMD_END
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [11:0] start;
		logic [11:0] len;
		logic [7:0]  index;
		logic [4:0]  level;
		logic [15:0] color;
	} cmd_t;

	function automatic logic [7:0] expand5(input logic [4:0] c);
		return {c, c[4:2]};
	endfunction

	function automatic logic [7:0] expand6(input logic [5:0] c);
		return {c, c[5:4]};
	endfunction

endpackage

// File: rtl/prsd_if.sv
`timescale 1ns / 1ps
// Handshake channels of the decoder: encoded byte input and run output.
interface prsd_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [7:0]  data_byte;
	logic [7:0]  palette_index;
	logic [15:0] palette_color;

	modport source (output valid, opcode, data_byte, palette_index, palette_color,
		input ready);
	modport sink (input valid, opcode, data_byte, palette_index, palette_color,
		output ready);
endinterface

interface prsd_out_if;
	logic        valid;
	logic        ready;
	logic [11:0] run_start;
	logic [11:0] run_length;
	logic [7:0]  alpha_out;
	logic [7:0]  red_out;
	logic [7:0]  green_out;
	logic [7:0]  blue_out;
	logic        line_end;

	modport source (output valid, run_start, run_length, alpha_out, red_out, green_out,
		blue_out, line_end, input ready);
	modport sink (input valid, run_start, run_length, alpha_out, red_out, green_out,
		blue_out, line_end, output ready);
endinterface

// File: rtl/prsd_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module prsd_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: rtl/prsd_front.sv
`timescale 1ns / 1ps
// Front end: accepts words, parses headers, tracks the cursor and clips runs.
module prsd_front #(
	parameter int unsigned MAX_LINE_WIDTH = prsd_pkg::MAX_LINE_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	prsd_in_if.sink        in_ch,
	input  logic [11:0]    line_width,
	input  logic [11:0]    start_offset,
	input  logic           q_full,
	output logic           push,
	output prsd_pkg::cmd_t push_cmd
);
	import prsd_pkg::*;

	localparam int unsigned CW0 = $clog2(MAX_LINE_WIDTH + 1);
	// cursor must also hold any start offset
	localparam int unsigned CW  = (CW0 > 12) ? CW0 : 12;

	phase_t          phase_q, phase_d;
	logic [5:0]      pend_cnt_q, pend_cnt_d;
	logic [4:0]      pend_alpha_q, pend_alpha_d;
	logic [CW-1:0]   cursor_q, cursor_d;
	logic            line_open_q;

	logic            accept, stream;
	logic [7:0]      byte_in;
	logic [CW-1:0]   cur;
	logic [11:0]     w_eff;
	logic            in_clip;
	logic [11:0]     rem, kept, fill;
	logic [CW:0]     adv_sum;
	logic [CW-1:0]   cursor_adv;

	logic [5:0]      run_n;
	logic            use_run;
	logic            line_end;
	cmd_kind_t       run_kind;

	assign in_ch.ready = !q_full;
	assign accept      = in_ch.valid && in_ch.ready;
	assign stream      = accept && (in_ch.opcode == OP_STREAM);
	assign byte_in     = in_ch.data_byte;

	// first byte of a line starts at the offset
	assign cur   = line_open_q ? cursor_q : CW'(start_offset);
	assign w_eff = (CW'(line_width) > CW'(MAX_LINE_WIDTH)) ? 12'(MAX_LINE_WIDTH) : line_width;

	assign in_clip = cur < CW'(w_eff);
	assign rem     = w_eff - cur[11:0];
	assign kept    = !in_clip ? 12'd0 : ((12'(run_n) < rem) ? 12'(run_n) : rem);
	assign fill    = in_clip ? rem : 12'd0;

	assign adv_sum    = (CW+1)'(cur) + (CW+1)'(run_n);
	assign cursor_adv = (adv_sum > (CW+1)'(MAX_LINE_WIDTH)) ? CW'(MAX_LINE_WIDTH)
		: adv_sum[CW-1:0];

	// next parse phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q) inside
			PH_A1_INDEX, PH_RA_INDEX, PH_REP_INDEX: begin
				phase_d = PH_HEADER;
			end
			PH_RA_LEVEL: begin
				phase_d = PH_RA_INDEX;
			end
			PH_LITERAL: begin
				if (pend_cnt_q == 6'd1) begin
					phase_d = PH_HEADER;
				end
			end
			PH_HEADER: begin
				phase_d = PH_HEADER;
				if (byte_in != 8'd0) begin
					case (byte_in[7:6])
						HDR_ALPHA:   phase_d = byte_in[5] ? PH_A1_INDEX : PH_RA_LEVEL;
						HDR_LITERAL: phase_d = (byte_in[5:0] != 6'd0) ? PH_LITERAL : PH_HEADER;
						HDR_REPEAT:  phase_d = PH_REP_INDEX;
						default:     phase_d = PH_HEADER;
					endcase
				end
			end
			default: begin
				phase_d = PH_HEADER;
			end
		endcase
	end

	// per-phase actions
	always_comb begin
		run_n        = 6'd0;
		use_run      = 1'b0;
		line_end     = 1'b0;
		run_kind     = CMD_CLEAR;
		pend_cnt_d   = pend_cnt_q;
		pend_alpha_d = pend_alpha_q;
		unique case (phase_q)
			PH_A1_INDEX: begin
				run_n    = 6'd1;
				use_run  = 1'b1;
				run_kind = CMD_ALPHA;
			end
			PH_RA_LEVEL: begin
				pend_alpha_d = (byte_in > ALPHA_MAX) ? ALPHA_MAX[4:0] : byte_in[4:0];
			end
			PH_RA_INDEX: begin
				run_n    = pend_cnt_q;
				use_run  = 1'b1;
				run_kind = CMD_ALPHA;
			end
			PH_LITERAL: begin
				pend_cnt_d = pend_cnt_q - 6'd1;
				run_n      = 6'd1;
				use_run    = 1'b1;
				run_kind   = CMD_OPAQUE;
			end
			PH_REP_INDEX: begin
				run_n    = pend_cnt_q;
				use_run  = 1'b1;
				run_kind = CMD_OPAQUE;
			end
			PH_HEADER: begin
				if (byte_in == 8'd0) begin
					line_end = 1'b1;
				end else begin
					case (byte_in[7:6])
						HDR_ALPHA: begin
							if (byte_in[5]) begin
								pend_alpha_d = byte_in[4:0];
							end else begin
								pend_cnt_d = {1'b0, byte_in[4:0]};
							end
						end
						HDR_LITERAL, HDR_REPEAT: begin
							pend_cnt_d = byte_in[5:0];
						end
						default: begin
							run_n    = byte_in[5:0];
							use_run  = 1'b1;
							run_kind = CMD_CLEAR;
						end
					endcase
				end
			end
			default: begin
				run_n = 6'd0;
			end
		endcase
	end

	assign cursor_d = use_run ? cursor_adv : cur;

	always_comb begin
		push_cmd.kind  = run_kind;
		push_cmd.start = cur[11:0];
		push_cmd.len   = kept;
		push_cmd.index = byte_in;
		push_cmd.level = pend_alpha_q;
		push_cmd.color = in_ch.palette_color;
		push           = 1'b0;
		if (accept && (in_ch.opcode == OP_PAL_WRITE)) begin
			push           = 1'b1;
			push_cmd.kind  = CMD_WRITE;
			push_cmd.index = in_ch.palette_index;
		end else if (stream && line_end) begin
			push          = 1'b1;
			push_cmd.kind = CMD_END;
			push_cmd.len  = fill;
		end else if (stream && use_run && (kept != 12'd0)) begin
			push = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			pend_cnt_q   <= 6'd0;
			pend_alpha_q <= 5'd0;
			cursor_q     <= CW'(START_OFFSET_RST);
			line_open_q  <= 1'b0;
		end else if (stream) begin
			phase_q      <= phase_d;
			pend_cnt_q   <= pend_cnt_d;
			pend_alpha_q <= pend_alpha_d;
			cursor_q     <= cursor_d;
			line_open_q  <= !line_end;
		end
	end

`ifndef SYNTHESIS
	a_literal_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LITERAL) |-> (pend_cnt_q != 6'd0))
		else $error("literal phase with zero count");
`endif
endmodule

// File: rtl/prsd_queue.sv
`timescale 1ns / 1ps
// Short command queue between the parser and the pixel back end.
module prsd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  prsd_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output prsd_pkg::cmd_t head
);
	import prsd_pkg::*;

	localparam int unsigned PW = $clog2(QUEUE_DEPTH);
	localparam int unsigned NW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [NW-1:0] count_q;

	assign full       = (count_q == NW'(QUEUE_DEPTH));
	assign head_valid = (count_q != NW'(0));
	assign head       = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");
`endif
endmodule

// File: rtl/prsd_back.sv
`timescale 1ns / 1ps
// Back end: palette writes and lookups, alpha scaling, output register.
module prsd_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  prsd_pkg::cmd_t head,
	output logic           pop,
	prsd_out_if.source     out_ch
);
	import prsd_pkg::*;

	cmd_t        s1_q;
	logic        s1_valid_q;
	logic        out_valid_q;
	logic        out_free, s1_go;

	logic        ram_we;
	logic [7:0]  ram_raddr;
	logic [15:0] ram_rdata;

	logic [9:0]  r_prod, b_prod;
	logic [10:0] g_prod;
	logic [7:0]  a_d, r_d, g_d, b_d;

	logic [11:0] start_q, len_q;
	logic [7:0]  a_q, r_q, g_q, b_q;
	logic        end_q;

	assign out_free = !out_valid_q || out_ch.ready;
	assign s1_go    = s1_valid_q && out_free;
	assign pop      = head_valid && (!s1_valid_q || out_free);
	assign ram_we   = pop && (head.kind == CMD_WRITE);
	// a stalled lookup re-reads its own entry to keep the read data alive
	assign ram_raddr = (s1_valid_q && !out_free) ? s1_q.index : head.index;

	prsd_ram #(
		.WIDTH (PAL_WIDTH),
		.DEPTH (PAL_DEPTH)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.waddr (head.index),
		.wdata (head.color),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign r_prod = 10'(ram_rdata[15:11]) * 10'(s1_q.level);
	assign g_prod = 11'(ram_rdata[10:5]) * 11'(s1_q.level);
	assign b_prod = 10'(ram_rdata[4:0]) * 10'(s1_q.level);

	always_comb begin
		a_d = 8'd0;
		r_d = 8'd0;
		g_d = 8'd0;
		b_d = 8'd0;
		unique case (s1_q.kind)
			CMD_ALPHA: begin
				a_d = {s1_q.level, 3'b000};
				r_d = expand5(r_prod[9:5]);
				g_d = expand6(g_prod[10:5]);
				b_d = expand5(b_prod[9:5]);
			end
			CMD_OPAQUE: begin
				a_d = 8'hFF;
				r_d = expand5(ram_rdata[15:11]);
				g_d = expand6(ram_rdata[10:5]);
				b_d = expand5(ram_rdata[4:0]);
			end
			default: begin
				a_d = 8'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			s1_q <= head;
		end
		if (s1_go) begin
			start_q <= s1_q.start;
			len_q   <= s1_q.len;
			a_q     <= a_d;
			r_q     <= r_d;
			g_q     <= g_d;
			b_q     <= b_d;
			end_q   <= (s1_q.kind == CMD_END);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				s1_valid_q <= (head.kind != CMD_WRITE);
			end else if (s1_go) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.run_start  = start_q;
	assign out_ch.run_length = len_q;
	assign out_ch.alpha_out  = a_q;
	assign out_ch.red_out    = r_q;
	assign out_ch.green_out  = g_q;
	assign out_ch.blue_out   = b_q;
	assign out_ch.line_end   = end_q;

`ifndef SYNTHESIS
	a_stall_holds_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !out_free) |-> !pop)
		else $error("queue popped while lookup stage stalled");
	a_end_transparent: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && end_q) |-> (a_q == 8'd0 && r_q == 8'd0 && g_q == 8'd0))
		else $error("line end run not transparent");
`endif
endmodule

// File: rtl/palette_rle_sprite_line_decoder_unit.sv
`timescale 1ns / 1ps
// Palette RLE sprite line decoder: top level with configuration registers.
//
// in_ch carries one word per cycle: a stream byte of the encoded line
// (opcode 0) or a palette entry write (opcode 1). out_ch delivers runs:
// start column, length, ARGB8888 color and a line end flag on the final
// transparent fill run that a zero header produces.
// Throughput is one input word per cycle while the queue is not full; the
// parser, a four-entry command queue and the palette lookup stage run
// concurrently. A word that gives a run passes through a queue entry, the
// lookup stage (palette RAM read) and the scaling into the output register.
// Words that give no run (literal, repeat and alpha headers, alpha levels,
// clipped pixels, palette writes) produce nothing on out_ch.
// When out_ch stalls, the lookup stage holds and the queue fills; in_ch
// ready drops only when the queue is full.
// cfg_we writes register cfg_index (0 line width, 1 start offset); write
// only while the block is idle. A new start offset applies from the next line.
// Reset empties the queue, clears the parser, width 320, offset 0.
// The palette is undefined until written.
module palette_rle_sprite_line_decoder_unit #(
	parameter int unsigned MAX_LINE_WIDTH = prsd_pkg::MAX_LINE_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data,
	prsd_in_if.sink     in_ch,
	prsd_out_if.source  out_ch
);
	import prsd_pkg::*;

	logic [11:0] line_width_q, start_offset_q;
	logic        q_full, push, pop, head_valid;
	cmd_t        push_cmd, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q   <= LINE_WIDTH_RST;
			start_offset_q <= START_OFFSET_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_LINE_WIDTH) begin
				line_width_q <= cfg_data;
			end
			if (cfg_index == CFG_START_OFFSET) begin
				start_offset_q <= cfg_data;
			end
		end
	end

	prsd_front #(
		.MAX_LINE_WIDTH (MAX_LINE_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_ch        (in_ch),
		.line_width   (line_width_q),
		.start_offset (start_offset_q),
		.q_full       (q_full),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	prsd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	prsd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.out_ch     (out_ch)
	);
endmodule

// File: verif/prsd_run_checker.sv
`timescale 1ns / 1ps
// Run predictor and checker for the palette RLE sprite line decoder.
module prsd_run_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data,
	prsd_in_if          in_mon,
	prsd_out_if         out_mon,
	output int unsigned mismatches,
	output int unsigned runs_pending
);
	import prsd_pkg::*;

	typedef struct packed {
		logic [11:0] start;
		logic [11:0] len;
		logic [7:0]  a;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic        last;
	} run_t;

	run_t        runs_due[$];
	logic [15:0] pal[PAL_DEPTH];
	phase_t      phase;
	logic [5:0]  cnt;
	logic [4:0]  lvl;
	int unsigned cur;
	bit          line_open;
	int unsigned width;
	int unsigned offset;

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// n pixels at the cursor, clipped at the width; clear marks a transparent skip
	task automatic emit_pixels(input int unsigned n, input logic [15:0] color, input bit opaque,
		input logic [4:0] level, input bit clear);
		int unsigned kept;
		int unsigned rc, gc, bc;
		logic [4:0]  r5, b5;
		logic [5:0]  g6;
		run_t        run;
		kept = 0;
		if (cur < width) kept = (n < width - cur) ? n : width - cur;
		run.start = cur[11:0];
		run.len = kept[11:0];
		run.last = 1'b0;
		cur = (cur + n > MAX_LINE_WIDTH_DEF) ? MAX_LINE_WIDTH_DEF : cur + n;
		if (kept == 0) return;
		rc = color[15:11];
		gc = color[10:5];
		bc = color[4:0];
		if (!opaque) begin
			rc = (rc * level) >> 5;
			gc = (gc * level) >> 5;
			bc = (bc * level) >> 5;
		end
		r5 = rc[4:0];
		g6 = gc[5:0];
		b5 = bc[4:0];
		if (clear) begin
			run.a = 8'd0;
			run.r = 8'd0;
			run.g = 8'd0;
			run.b = 8'd0;
		end else begin
			run.a = opaque ? 8'hff : {level, 3'b000};
			run.r = {r5, r5[4:2]};
			run.g = {g6, g6[5:4]};
			run.b = {b5, b5[4:2]};
		end
		runs_due.push_back(run);
	endtask

	task automatic decode_word(input logic op, input logic [7:0] b, input logic [7:0] idx,
		input logic [15:0] col);
		int unsigned fill;
		run_t        run;
		if (op == OP_PAL_WRITE) begin
			pal[idx] = col;
			return;
		end
		if (!line_open) begin
			cur = offset;
			line_open = 1'b1;
		end
		case (phase)
			PH_A1_INDEX: begin
				phase = PH_HEADER;
				emit_pixels(1, pal[b], 1'b0, lvl, 1'b0);
			end
			PH_RA_LEVEL: begin
				lvl = (b > ALPHA_MAX) ? ALPHA_MAX[4:0] : b[4:0];
				phase = PH_RA_INDEX;
			end
			PH_RA_INDEX: begin
				phase = PH_HEADER;
				emit_pixels(cnt, pal[b], 1'b0, lvl, 1'b0);
			end
			PH_LITERAL: begin
				cnt = cnt - 6'd1;
				if (cnt == 6'd0) phase = PH_HEADER;
				emit_pixels(1, pal[b], 1'b1, 5'd0, 1'b0);
			end
			PH_REP_INDEX: begin
				phase = PH_HEADER;
				emit_pixels(cnt, pal[b], 1'b1, 5'd0, 1'b0);
			end
			default: begin
				phase = PH_HEADER;
				if (b == 8'd0) begin
					// line end: fill the rest of the canvas, then rearm for the next line
					fill = (cur < width) ? width - cur : 0;
					run = '{start: cur[11:0], len: fill[11:0], a: 8'd0, r: 8'd0, g: 8'd0,
						b: 8'd0, last: 1'b1};
					runs_due.push_back(run);
					line_open = 1'b0;
					cur = offset;
				end else begin
					case (b[7:6])
						HDR_ALPHA: begin
							if (b[5]) begin
								lvl = b[4:0];
								phase = PH_A1_INDEX;
							end else begin
								cnt = {1'b0, b[4:0]};
								phase = PH_RA_LEVEL;
							end
						end
						HDR_LITERAL: begin
							cnt = b[5:0];
							if (cnt != 6'd0) phase = PH_LITERAL;
						end
						HDR_REPEAT: begin
							cnt = b[5:0];
							phase = PH_REP_INDEX;
						end
						default: emit_pixels(b[5:0], 16'h0000, 1'b0, 5'd0, 1'b1);
					endcase
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		run_t want;
		if (!arst_n) begin
			mismatches = 0;
			runs_due.delete();
			foreach (pal[i]) pal[i] = '0;
			phase = PH_HEADER;
			cnt = '0;
			lvl = '0;
			width = LINE_WIDTH_RST;
			offset = START_OFFSET_RST;
			cur = START_OFFSET_RST;
			line_open = 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_LINE_WIDTH) width = cfg_data;
				else offset = cfg_data;
			end
			if (out_mon.valid && out_mon.ready) begin
				if (runs_due.size() == 0) begin
					$error("unexpected run word at column %0d", out_mon.run_start);
					mismatches++;
				end else begin
					want = runs_due.pop_front();
					check_field("run_start", want.start, out_mon.run_start);
					check_field("run_length", want.len, out_mon.run_length);
					check_field("alpha_out", want.a, out_mon.alpha_out);
					check_field("red_out", want.r, out_mon.red_out);
					check_field("green_out", want.g, out_mon.green_out);
					check_field("blue_out", want.b, out_mon.blue_out);
					check_field("line_end", want.last, out_mon.line_end);
				end
			end
			if (in_mon.valid && in_mon.ready)
				decode_word(in_mon.opcode, in_mon.data_byte, in_mon.palette_index,
					in_mon.palette_color);
		end
		runs_pending = runs_due.size();
	end

endmodule

// File: verif/tb_palette_rle_sprite_line_decoder_unit.sv
`timescale 1ns / 1ps
// Top of the decoder testbench: clock, reset, stimulus, receiver stalls and verdict.
module tb_palette_rle_sprite_line_decoder_unit;
	import prsd_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned HOLD_CYCLES  = 80;
	localparam int unsigned N_PHASES     = 8;
	localparam int unsigned BURST_WORDS  = 40;
	localparam logic        A1_FLAG      = 1'b1;
	localparam logic        RA_FLAG      = 1'b0;
	localparam logic [7:0]  LINE_END_HDR = 8'h00;

	typedef enum int unsigned {
		K_ALPHA1,
		K_REP_ALPHA,
		K_LITERAL,
		K_REP_OPAQUE,
		K_SKIP
	} code_kind_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [11:0] cfg_data;
	int unsigned fail_count;
	int unsigned pending_runs;
	int unsigned words_sent;
	int unsigned cycle_cnt;
	bit          in_gaps;
	bit          out_gaps;
	bit          hold_req;

	prsd_in_if  in_ch();
	prsd_out_if out_ch();

	palette_rle_sprite_line_decoder_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	prsd_run_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_mon       (in_ch),
		.out_mon      (out_ch),
		.mismatches   (fail_count),
		.runs_pending (pending_runs)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Regression FAIL");
		$finish;
	end

	// run receiver: random stalls, plus a long hold-off on request
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			out_ch.ready = !(out_gaps && $urandom_range(99) < 18);
		end
	end

	task automatic send_word(input logic op, input logic [7:0] b, input logic [7:0] idx,
		input logic [15:0] col);
		@(negedge clk);
		while (in_gaps && $urandom_range(99) < 18) begin
			in_ch.valid = 1'b0;
			in_ch.data_byte = 8'($urandom);
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.opcode = op;
		in_ch.data_byte = b;
		in_ch.palette_index = idx;
		in_ch.palette_color = col;
		do @(posedge clk); while (!in_ch.ready);
		words_sent++;
	endtask

	task automatic put_byte(input logic [7:0] b);
		send_word(OP_STREAM, b, 8'($urandom), 16'($urandom));
	endtask

	task automatic pal_write(input logic [7:0] idx, input logic [15:0] col);
		send_word(OP_PAL_WRITE, 8'($urandom), idx, col);
	endtask

	// wait for the block to go idle before touching a register
	task automatic settle();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (pending_runs != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [11:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// mostly short runs, now and then up to the field maximum
	function automatic logic [5:0] pick_count(input int unsigned hi);
		return ($urandom_range(99) < 75) ? 6'($urandom_range(0, 7)) : 6'($urandom_range(0, hi));
	endfunction

	task automatic send_code(input code_kind_t kind);
		logic [5:0] n;
		case (kind)
			K_ALPHA1: begin
				put_byte({HDR_ALPHA, A1_FLAG, 5'($urandom)});
				put_byte(8'($urandom));
			end
			K_REP_ALPHA: begin
				// count 0 would encode the line end header
				n = pick_count(31);
				if (n == 6'd0) n = 6'd1;
				put_byte({HDR_ALPHA, RA_FLAG, n[4:0]});
				put_byte(($urandom_range(99) < 60) ? 8'($urandom_range(0, 31)) : 8'($urandom));
				put_byte(8'($urandom));
			end
			K_LITERAL: begin
				n = pick_count(63);
				put_byte({HDR_LITERAL, n});
				repeat (n) put_byte(8'($urandom));
			end
			K_REP_OPAQUE: begin
				put_byte({HDR_REPEAT, pick_count(63)});
				put_byte(8'($urandom));
			end
			default: put_byte({HDR_SKIP, pick_count(63)});
		endcase
	endtask

	task automatic send_line();
		int unsigned n_codes;
		n_codes = $urandom_range(1, 8);
		repeat (n_codes) begin
			if ($urandom_range(99) < 12) begin
				// noise: stray byte or palette rewrite, may break the code in progress
				if ($urandom_range(1)) put_byte(8'($urandom));
				else pal_write(8'($urandom), 16'($urandom));
			end else begin
				send_code(code_kind_t'($urandom_range(0, 4)));
			end
		end
		put_byte(LINE_END_HDR);
	endtask

	initial begin
		logic [11:0] w, o;
		int unsigned phase_end;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_LINE_WIDTH;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.opcode = OP_STREAM;
		in_ch.data_byte = '0;
		in_ch.palette_index = '0;
		in_ch.palette_color = '0;
		in_gaps = 1'b1;
		out_gaps = 1'b1;
		hold_req = 1'b0;
		words_sent = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// fill the whole palette so no index byte ever reads an unwritten entry
		for (int i = 0; i < PAL_DEPTH; i++)
			pal_write(8'(i), (i == 0) ? 16'h0000 : (i == 255) ? 16'hffff : 16'($urandom));

		// receiver holds off while the directed line fills the queue and stalls the input
		hold_req = 1'b1;

		// directed line at reset config: every code, zero counts, alpha saturation, clipping
		put_byte({HDR_ALPHA, A1_FLAG, 5'd0});
		put_byte(8'hff);
		put_byte({HDR_ALPHA, A1_FLAG, 5'd31});
		put_byte(8'hff);
		put_byte({HDR_ALPHA, RA_FLAG, 5'd31});
		put_byte(8'hff);
		put_byte(8'hff);
		put_byte({HDR_ALPHA, RA_FLAG, 5'd1});
		put_byte(8'd31);
		put_byte(8'h00);
		put_byte({HDR_LITERAL, 6'd0});
		put_byte({HDR_LITERAL, 6'd2});
		put_byte(8'h00);
		put_byte(8'hff);
		pal_write(8'h80, 16'h07e0);
		put_byte({HDR_REPEAT, 6'd0});
		put_byte(8'h80);
		put_byte({HDR_SKIP, 6'd0});
		put_byte({HDR_SKIP, 6'd63});
		put_byte({HDR_REPEAT, 6'd63});
		put_byte(8'h80);
		put_byte({HDR_SKIP, 6'd63});
		put_byte({HDR_SKIP, 6'd63});
		put_byte({HDR_REPEAT, 6'd63});
		put_byte(8'hff);
		// wholly past the width, bytes still consumed
		put_byte({HDR_LITERAL, 6'd2});
		put_byte(8'h01);
		put_byte(8'h02);
		put_byte(LINE_END_HDR);

		for (int p = 0; p < N_PHASES; p++) begin
			case (p)
				0: begin w = 12'd320;  o = 12'd0;    end
				1: begin w = 12'd4095; o = 12'd0;    end
				2: begin w = 12'd1;    o = 12'd0;    end
				3: begin w = 12'd0;    o = 12'd5;    end
				4: begin w = 12'd4095; o = 12'd4095; end
				5: begin w = 12'd64;   o = 12'd40;   end
				6: begin w = 12'd4000; o = 12'd3990; end
				default: begin
					w = 12'($urandom_range(1, 4095));
					o = 12'($urandom_range(0, 4095));
				end
			endcase
			settle();
			write_reg(CFG_LINE_WIDTH, w);
			write_reg(CFG_START_OFFSET, o);
			in_gaps = (p != 6);
			out_gaps = (p != 6);
			// one line per phase, a long burst of lines with no idling in phase 6
			phase_end = words_sent + ((p == 6) ? BURST_WORDS : 1);
			while (words_sent < phase_end) send_line();
		end

		@(negedge clk);
		in_ch.valid = 1'b0;
		while (pending_runs != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending_runs == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
